// File: hdl/gdc_pkg.sv
package gdc_pkg;

   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int YEAR_W     = 14;
   localparam int DAY_NUM_W  = 22;
   localparam int MOD100_W   = 7;
   localparam int MOD400_W   = 9;
   localparam int QUOT_W     = 8;

   localparam logic [MONTH_W-1:0]   DEF_MONTH   = 4'd1;
   localparam logic [DAY_W-1:0]     DEF_DAY     = 5'd1;
   localparam logic [YEAR_W-1:0]    DEF_YEAR    = 14'd2000;
   localparam logic [DAY_NUM_W-1:0] DEF_DAY_NUM = 22'd730120;
   localparam logic [MOD100_W-1:0]  DEF_MOD100  = 7'd0;
   localparam logic [MOD400_W-1:0]  DEF_MOD400  = 9'd0;

   localparam logic [YEAR_W-1:0]    YEAR_MIN    = 14'd1;
   localparam logic [YEAR_W-1:0]    YEAR_MAX    = 14'd9999;
   localparam logic [MONTH_W-1:0]   MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0]   MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0]   MONTH_LAST  = 4'd12;
   localparam logic [DAY_W-1:0]     DAY_FIRST   = 5'd1;
   localparam logic [DAY_W-1:0]     DAY_DEC_END = 5'd31;
   localparam logic [MOD100_W-1:0]  MOD100_LAST = 7'd99;
   localparam logic [MOD400_W-1:0]  MOD400_LAST = 9'd399;

   // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + 13;
   localparam int DAYS_YEAR   = 365;
   localparam int CENTURY     = 100;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      MODE_LOAD,
      MODE_NEXT,
      MODE_PREV,
      MODE_DIFF
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_INVALID,
      STATUS_LIMIT
   } status_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [MONTH_W-1:0] in_month;
      logic [DAY_W-1:0]   in_day;
      logic [YEAR_W-1:0]  in_year;
   } req_type;

   typedef struct packed {
      logic [MONTH_W-1:0]   out_month;
      logic [DAY_W-1:0]     out_day;
      logic [YEAR_W-1:0]    out_year;
      logic [DAY_NUM_W-1:0] diff_days;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      mode_type             mode;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [YEAR_W-1:0]    year;
      logic [MOD100_W-1:0]  mod100;
      logic [MOD400_W-1:0]  mod400;
      logic [DAY_NUM_W-1:0] base_days;
      logic [DAY_NUM_W-1:0] extra_days;
      logic                 invalid;
   } stage_type;

   typedef struct packed {
      mode_type             mode;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [YEAR_W-1:0]    year;
      logic [MOD100_W-1:0]  mod100;
      logic [MOD400_W-1:0]  mod400;
      logic [DAY_NUM_W-1:0] day_num;
      logic                 invalid;
   } cmd_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      unique case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

// File: hdl/gdc_front.sv
module gdc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  gdc_pkg::req_type           req,
   input  logic [gdc_pkg::QUEUE_AW:0] queue_count,
   output logic                       push,
   output gdc_pkg::cmd_type           push_cmd
);
   import gdc_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   req_type               s1_req_ff;
   logic [QUOT_W-1:0]     s1_quot_ff, s1_quot_in;
   logic [PROD_W-1:0]     product;

   logic                  s2_valid_ff;
   stage_type             s2_ff, s2_in;

   logic [QUEUE_AW:0]     in_flight;
   logic [YEAR_W-1:0]     year, prev_year, rem_full;
   logic [MONTH_W-1:0]    month;
   logic [DAY_W-1:0]      day, mlen;
   logic [MOD100_W-1:0]   rem100;
   logic [QUOT_W-1:0]     quot_prev;
   logic                  leap, century;

   // credit check: queue plus items still in the front pipe
   assign in_flight   = queue_count + (QUEUE_AW+1)'(s1_valid_ff) + (QUEUE_AW+1)'(s2_valid_ff);
   assign req_stall   = in_flight >= (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign s1_valid_in = req_valid && !req_stall;

   assign product    = PROD_W'(req.in_year) * PROD_W'(RECIP_100);
   assign s1_quot_in = product[RECIP_SHIFT +: QUOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff  <= req;
      s1_quot_ff <= s1_quot_in;
      s2_ff      <= s2_in;
   end

   // classify: remainders, leap year, validity, day number terms
   always_comb begin
      year      = s1_req_ff.in_year;
      month     = s1_req_ff.in_month;
      day       = s1_req_ff.in_day;
      rem_full  = year - YEAR_W'(YEAR_W'(s1_quot_ff) * YEAR_W'(CENTURY));
      rem100    = rem_full[MOD100_W-1:0];
      century   = rem100 == '0;
      leap      = (year[1:0] == 2'b00 && !century) || (century && s1_quot_ff[1:0] == 2'b00);
      mlen      = month_len(month, leap);
      quot_prev = s1_quot_ff - QUOT_W'(century);
      prev_year = year - YEAR_MIN;

      s2_in.mode       = mode_type'(s1_req_ff.mode);
      s2_in.month      = month;
      s2_in.day        = day;
      s2_in.year       = year;
      s2_in.mod100     = rem100;
      s2_in.mod400     = MOD400_W'(rem100) + MOD400_W'(MOD400_W'(s1_quot_ff[1:0]) * MOD400_W'(CENTURY));
      s2_in.base_days  = DAY_NUM_W'(prev_year) * DAY_NUM_W'(DAYS_YEAR);
      s2_in.extra_days = DAY_NUM_W'(prev_year[YEAR_W-1:2]) - DAY_NUM_W'(quot_prev)
                       + DAY_NUM_W'(quot_prev[QUOT_W-1:2]) + DAY_NUM_W'(days_before(month))
                       + DAY_NUM_W'(month > MONTH_FEB && leap) + DAY_NUM_W'(day);
      s2_in.invalid    = !(year >= YEAR_MIN && year <= YEAR_MAX && month >= MONTH_FIRST
                           && month <= MONTH_LAST && day >= DAY_FIRST && day <= mlen);
   end

   // invalid dates become the default date
   always_comb begin
      push             = s2_valid_ff;
      push_cmd.mode    = s2_ff.mode;
      push_cmd.invalid = s2_ff.invalid;
      if (s2_ff.invalid) begin
         push_cmd.month   = DEF_MONTH;
         push_cmd.day     = DEF_DAY;
         push_cmd.year    = DEF_YEAR;
         push_cmd.mod100  = DEF_MOD100;
         push_cmd.mod400  = DEF_MOD400;
         push_cmd.day_num = DEF_DAY_NUM;
      end else begin
         push_cmd.month   = s2_ff.month;
         push_cmd.day     = s2_ff.day;
         push_cmd.year    = s2_ff.year;
         push_cmd.mod100  = s2_ff.mod100;
         push_cmd.mod400  = s2_ff.mod400;
         push_cmd.day_num = s2_ff.base_days + s2_ff.extra_days;
      end
   end

endmodule

// File: hdl/gdc_queue.sv
module gdc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gdc_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output logic                       head_valid,
   output gdc_pkg::cmd_type           head_cmd,
   output logic [gdc_pkg::QUEUE_AW:0] count
);
   import gdc_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> !push || pop)
      else $error("push into full queue");

endmodule

// File: hdl/gdc_back.sv
module gdc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  gdc_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gdc_pkg::rsp_type rsp
);
   import gdc_pkg::*;

   logic [MONTH_W-1:0]   cur_month_ff, cur_month_in;
   logic [DAY_W-1:0]     cur_day_ff, cur_day_in;
   logic [YEAR_W-1:0]    cur_year_ff, cur_year_in;
   logic [MOD100_W-1:0]  cur_mod100_ff, cur_mod100_in;
   logic [MOD400_W-1:0]  cur_mod400_ff, cur_mod400_in;
   logic [DAY_NUM_W-1:0] cur_dn_ff, cur_dn_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 cur_leap, at_max, at_min;
   logic [DAY_W-1:0]     cur_mlen;
   logic [DAY_NUM_W-1:0] diff;
   status_type           status;

   assign pop       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign cur_leap = (cur_year_ff[1:0] == 2'b00 && cur_mod100_ff != '0) || cur_mod400_ff == '0;
   assign cur_mlen = month_len(cur_month_ff, cur_leap);
   assign at_max   = cur_month_ff == MONTH_LAST && cur_day_ff == DAY_DEC_END
                     && cur_year_ff == YEAR_MAX;
   assign at_min   = cur_month_ff == MONTH_FIRST && cur_day_ff == DAY_FIRST
                     && cur_year_ff == YEAR_MIN;

   always_comb begin
      cur_month_in  = cur_month_ff;
      cur_day_in    = cur_day_ff;
      cur_year_in   = cur_year_ff;
      cur_mod100_in = cur_mod100_ff;
      cur_mod400_in = cur_mod400_ff;
      cur_dn_in     = cur_dn_ff;
      diff          = '0;
      status        = STATUS_OK;
      unique case (head_cmd.mode)
         MODE_LOAD: begin
            cur_month_in  = head_cmd.month;
            cur_day_in    = head_cmd.day;
            cur_year_in   = head_cmd.year;
            cur_mod100_in = head_cmd.mod100;
            cur_mod400_in = head_cmd.mod400;
            cur_dn_in     = head_cmd.day_num;
            status        = head_cmd.invalid ? STATUS_INVALID : STATUS_OK;
         end
         MODE_NEXT: begin
            if (at_max) begin
               status = STATUS_LIMIT;
            end else begin
               cur_dn_in = cur_dn_ff + 1'b1;
               if (cur_day_ff < cur_mlen) begin
                  cur_day_in = cur_day_ff + 1'b1;
               end else begin
                  cur_day_in = DAY_FIRST;
                  if (cur_month_ff < MONTH_LAST) begin
                     cur_month_in = cur_month_ff + 1'b1;
                  end else begin
                     cur_month_in  = MONTH_FIRST;
                     cur_year_in   = cur_year_ff + 1'b1;
                     cur_mod100_in = (cur_mod100_ff == MOD100_LAST) ? '0 : cur_mod100_ff + 1'b1;
                     cur_mod400_in = (cur_mod400_ff == MOD400_LAST) ? '0 : cur_mod400_ff + 1'b1;
                  end
               end
            end
         end
         MODE_PREV: begin
            if (at_min) begin
               status = STATUS_LIMIT;
            end else begin
               cur_dn_in = cur_dn_ff - 1'b1;
               if (cur_day_ff > DAY_FIRST) begin
                  cur_day_in = cur_day_ff - 1'b1;
               end else if (cur_month_ff > MONTH_FIRST) begin
                  cur_month_in = cur_month_ff - 1'b1;
                  cur_day_in   = month_len(cur_month_ff - 1'b1, cur_leap);
               end else begin
                  cur_month_in  = MONTH_LAST;
                  cur_day_in    = DAY_DEC_END;
                  cur_year_in   = cur_year_ff - 1'b1;
                  cur_mod100_in = (cur_mod100_ff == '0) ? MOD100_LAST : cur_mod100_ff - 1'b1;
                  cur_mod400_in = (cur_mod400_ff == '0) ? MOD400_LAST : cur_mod400_ff - 1'b1;
               end
            end
         end
         MODE_DIFF: begin
            diff   = (cur_dn_ff >= head_cmd.day_num) ? cur_dn_ff - head_cmd.day_num
                                                     : head_cmd.day_num - cur_dn_ff;
            status = head_cmd.invalid ? STATUS_INVALID : STATUS_OK;
         end
      endcase
      rsp_in.out_month = cur_month_in;
      rsp_in.out_day   = cur_day_in;
      rsp_in.out_year  = cur_year_in;
      rsp_in.diff_days = diff;
      rsp_in.status    = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_month_ff  <= DEF_MONTH;
         cur_day_ff    <= DEF_DAY;
         cur_year_ff   <= DEF_YEAR;
         cur_mod100_ff <= DEF_MOD100;
         cur_mod400_ff <= DEF_MOD400;
         cur_dn_ff     <= DEF_DAY_NUM;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            cur_month_ff  <= cur_month_in;
            cur_day_ff    <= cur_day_in;
            cur_year_ff   <= cur_year_in;
            cur_mod100_ff <= cur_mod100_in;
            cur_mod400_ff <= cur_mod400_in;
            cur_dn_ff     <= cur_dn_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cur_year_ff >= YEAR_MIN && cur_year_ff <= YEAR_MAX && cur_day_ff >= DAY_FIRST
      && cur_month_ff >= MONTH_FIRST && cur_month_ff <= MONTH_LAST)
      else $error("stored date out of calendar range");

   assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.mode == MODE_NEXT && !at_max) |=> cur_dn_ff == $past(cur_dn_ff) + 1'b1)
      else $error("day number not advanced on next day");

   assert property (@(posedge clock) disable iff (reset)
      cur_mod100_ff <= MOD100_LAST && cur_mod400_ff <= MOD400_LAST)
      else $error("year remainder out of range");

endmodule

// File: hdl/gregorian_date_up_down_counter_top.sv
// channel    direction  handshake          payload
// req        in         req_valid/stall    gdc_pkg::req_type  (mode, supplied date)
// rsp        out        rsp_valid/stall    gdc_pkg::rsp_type  (date, diff_days, status)
//
// one request per cycle sustained unless stalled; responses pass s1, s2, queue, rsp_ff
// front: year / 100 by reciprocal multiply, then validation and day number, two stages
// back: unless stalled one update per cycle off a 4-entry queue; day number incremental
// reset: date 1/1/2000, queue and pipes empty, no clearing pass
// rsp_stall holds the response register; req_stall rises when the queue credit runs out
module gregorian_date_up_down_counter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gdc_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gdc_pkg::rsp_type rsp
);
   import gdc_pkg::*;

   logic              push, pop, head_valid;
   cmd_type           push_cmd, head_cmd;
   logic [QUEUE_AW:0] queue_count;

   gdc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .queue_count (queue_count),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   gdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .count      (queue_count)
   );

   gdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

endmodule
